@@ rtl/euclidean_rhythm_generator_assert.svh @@
// Assertion macros shared by the Euclidean rhythm generator modules.
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_ASSERT_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define ERG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define ERG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/erg_pkg.sv @@
// Shared types and constants for the Euclidean rhythm generator.
`timescale 1ns / 1ps

package erg_pkg;

   // Step counts, hit counts, group lengths and shift amounts all fit in 6 bits.
   localparam int CNT_W = 6;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic    shift_left;
      cnt_type amount;
   } shift_ctl_type;

endpackage

@@ rtl/erg_shifter.sv @@
// Shared barrel shifter used for folding, layout and rotation.
`timescale 1ns / 1ps

module erg_shifter #(
   parameter int WIDTH = 32
) (
   input  erg_pkg::shift_ctl_type ctl,
   input  logic [WIDTH-1:0]       data_in,
   output logic [WIDTH-1:0]       data_out
);

   always_comb begin
      if (ctl.shift_left) begin
         data_out = data_in << ctl.amount;
      end else begin
         data_out = data_in >> ctl.amount;
      end
   end

endmodule

@@ rtl/erg_modulo.sv @@
// Restoring remainder unit: reduces the rotation modulo the step count, one bit per cycle.
`timescale 1ns / 1ps
`include "euclidean_rhythm_generator_assert.svh"

module erg_modulo (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [7:0]        dividend,
   input  erg_pkg::cnt_type  divisor,
   output logic              done,
   output erg_pkg::cnt_type  remainder
);

   logic [7:0]       rem_ff, rem_in;
   erg_pkg::cnt_type div_ff, div_in;
   logic [2:0]       bit_ff, bit_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [13:0]      trial;

   assign trial = 14'(div_ff) << bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         div_in = divisor;
         bit_in = 3'd7;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (14'(rem_ff) >= trial) begin
            rem_in = rem_ff - 8'(trial);
         end
         bit_in = bit_ff - 3'd1;
         if (bit_ff == 3'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      bit_ff <= bit_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = erg_pkg::cnt_type'(rem_ff);

   // With a nonzero divisor the remainder must end below it.
   `ERG_ASSERT_NOW(a_rem_below_div, done_ff && (div_ff != '0), rem_ff < 8'(div_ff), "remainder not reduced")
   // Completion is a single-cycle pulse.
   `ERG_ASSERT_NEXT(a_done_pulse, done_ff, !done_ff, "done held longer than one cycle")
   // A new operation never reports completion on the following cycle.
   `ERG_ASSERT_NEXT(a_start_runs, start, run_ff && !done_ff, "operation did not start")

endmodule

@@ rtl/euclidean_rhythm_generator.sv @@
// Special cases (no steps, no hits, all hits) strobe once the remainder unit is done;
// otherwise the request runs F folding rounds, then lays out G groups (G <= steps).
// The layout loop runs through the shared shifter, one group per cycle.
// One request is in flight at a time; busy drops in the cycle the result strobes.
// The result strobe lasts one cycle and cannot be stalled.
// Reset is synchronous and clears the sequencer and the strobe; no clearing pass is needed.
`timescale 1ns / 1ps
`include "euclidean_rhythm_generator_assert.svh"

module euclidean_rhythm_generator #(
   parameter int MAX_STEPS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [5:0]  req_hit_count,
   input  logic [5:0]  req_step_count,
   input  logic [7:0]  req_rotate_by,
   output logic        rsp_valid,
   output logic [31:0] rsp_pattern_bits
);

   localparam int PW = MAX_STEPS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FOLD,
      ST_LAYOUT,
      ST_ROT_R,
      ST_ROT_L
   } state_type;

   state_type        state_ff, state_in;
   erg_pkg::cnt_type steps_ff, steps_in;
   erg_pkg::cnt_type hits_ff, hits_in;
   erg_pkg::cnt_type left_ff, left_in;
   erg_pkg::cnt_type right_ff, right_in;
   erg_pkg::cnt_type len_a_ff, len_a_in;
   erg_pkg::cnt_type len_b_ff, len_b_in;
   erg_pkg::cnt_type pos_ff, pos_in;
   erg_pkg::cnt_type rot_ff, rot_in;
   logic [PW-1:0]    grp_a_ff, grp_a_in;
   logic [PW-1:0]    grp_b_ff, grp_b_in;
   logic [PW-1:0]    pat_ff, pat_in;
   logic [PW-1:0]    tmp_ff, tmp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_pattern_ff, rsp_pattern_in;

   erg_pkg::cnt_type      steps_sat, hits_clamped, pairs, mod_rem;
   logic                  accept, mod_done;
   logic [PW-1:0]         step_mask, shift_data, shift_out;
   erg_pkg::shift_ctl_type shift_ctl;

   assign accept = start && (state_ff == ST_IDLE);

   assign steps_sat = (32'(req_step_count) > 32'(MAX_STEPS)) ?
                      erg_pkg::cnt_type'(MAX_STEPS) : req_step_count;
   assign hits_clamped = (req_hit_count > steps_sat) ? steps_sat : req_hit_count;
   assign pairs = (left_ff < right_ff) ? left_ff : right_ff;

   always_comb begin
      for (int i = 0; i < PW; i++) begin
         step_mask[i] = (i < int'(steps_ff));
      end
   end

   erg_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_rotate_by),
      .divisor   (steps_sat),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Shifter operand selection per phase.
   always_comb begin
      shift_ctl.shift_left = 1'b1;
      shift_ctl.amount     = '0;
      shift_data           = pat_ff;
      unique case (state_ff)
         ST_FOLD: begin
            shift_ctl.amount = len_a_ff;
            shift_data       = grp_b_ff;
         end
         ST_LAYOUT: begin
            shift_ctl.amount = pos_ff;
            shift_data       = (left_ff != '0) ? grp_a_ff : grp_b_ff;
         end
         ST_ROT_R: begin
            shift_ctl.shift_left = 1'b0;
            shift_ctl.amount     = rot_ff;
         end
         ST_ROT_L: begin
            shift_ctl.amount = steps_ff - rot_ff;
         end
         default: begin
         end
      endcase
   end

   erg_shifter #(.WIDTH(PW)) u_shifter (
      .ctl      (shift_ctl),
      .data_in  (shift_data),
      .data_out (shift_out)
   );

   always_comb begin
      state_in       = state_ff;
      steps_in       = steps_ff;
      hits_in        = hits_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      len_a_in       = len_a_ff;
      len_b_in       = len_b_ff;
      pos_in         = pos_ff;
      rot_in         = rot_ff;
      grp_a_in       = grp_a_ff;
      grp_b_in       = grp_b_ff;
      pat_in         = pat_ff;
      tmp_in         = tmp_ff;
      rsp_valid_in   = 1'b0;
      rsp_pattern_in = rsp_pattern_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               steps_in = steps_sat;
               hits_in  = hits_clamped;
               grp_a_in = PW'(1);
               grp_b_in = '0;
               len_a_in = erg_pkg::cnt_type'(1);
               len_b_in = erg_pkg::cnt_type'(1);
               left_in  = hits_clamped;
               right_in = steps_sat - hits_clamped;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               rot_in = mod_rem;
               if ((steps_ff == '0) || (hits_ff == '0)) begin
                  rsp_pattern_in = '0;
                  rsp_valid_in   = 1'b1;
                  state_in       = ST_IDLE;
               end else if (hits_ff == steps_ff) begin
                  rsp_pattern_in = 32'(step_mask);
                  rsp_valid_in   = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_FOLD;
               end
            end
         end
         ST_FOLD: begin
            // All leading groups share one pattern and all remainder groups another,
            // so a round folds the two group patterns and updates the counts.
            if (right_ff > erg_pkg::cnt_type'(1)) begin
               grp_a_in = grp_a_ff | shift_out;
               len_a_in = len_a_ff + len_b_ff;
               left_in  = pairs;
               if (left_ff > right_ff) begin
                  grp_b_in = grp_a_ff;
                  len_b_in = len_a_ff;
                  right_in = left_ff - pairs;
               end else begin
                  right_in = right_ff - pairs;
               end
            end else begin
               pat_in   = '0;
               pos_in   = '0;
               state_in = ST_LAYOUT;
            end
         end
         ST_LAYOUT: begin
            if (left_ff != '0) begin
               pat_in  = pat_ff | shift_out;
               pos_in  = pos_ff + len_a_ff;
               left_in = left_ff - erg_pkg::cnt_type'(1);
            end else if (right_ff != '0) begin
               pat_in   = pat_ff | shift_out;
               pos_in   = pos_ff + len_b_ff;
               right_in = right_ff - erg_pkg::cnt_type'(1);
            end else begin
               state_in = ST_ROT_R;
            end
         end
         ST_ROT_R: begin
            tmp_in   = shift_out;
            state_in = ST_ROT_L;
         end
         ST_ROT_L: begin
            rsp_pattern_in = 32'((tmp_ff | shift_out) & step_mask);
            rsp_valid_in   = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      steps_ff       <= steps_in;
      hits_ff        <= hits_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      len_a_ff       <= len_a_in;
      len_b_ff       <= len_b_in;
      pos_ff         <= pos_in;
      rot_ff         <= rot_in;
      grp_a_ff       <= grp_a_in;
      grp_b_ff       <= grp_b_in;
      pat_ff         <= pat_in;
      tmp_ff         <= tmp_in;
      rsp_pattern_ff <= rsp_pattern_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pattern_bits = rsp_pattern_ff;

   // A transaction always leaves the sequencer busy on the next cycle.
   `ERG_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not start")
   // Results only appear once the sequencer has returned to idle.
   `ERG_ASSERT_NOW(a_rsp_idle, rsp_valid_ff, !busy, "result strobed while busy")
   // No hit may land at or above the step count.
   `ERG_ASSERT_NOW(a_rsp_masked, rsp_valid_ff, (rsp_pattern_ff & ~32'(step_mask)) == '0, "hit beyond step count")
   // The layout never runs past the end of the pattern.
   `ERG_ASSERT_NOW(a_layout_pos, state_ff == ST_LAYOUT, pos_ff <= steps_ff, "layout position past step count")

endmodule

@@ tb/sv/tb_euclidean_rhythm_generator.sv @@
// Self-checking testbench for the Euclidean rhythm generator with a built-in pattern predictor.
`timescale 1ns / 1ps

module tb_euclidean_rhythm_generator;

   localparam int MAX_STEPS     = 32;
   localparam int RANDOM_ITEMS  = 1130;
   localparam int QUIET_FIRST   = 400;
   localparam int QUIET_LAST    = 650;
   localparam int STALL_LIMIT   = 1000;
   localparam int END_DRAIN     = 100;
   localparam int MAX_GAP       = 80;

   // Keeps the patterns still owed by the block and compares each strobed result.
   class rhythm_scoreboard;
      logic [31:0] expected_patterns[$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         mismatches = 0;
         checked = 0;
      endfunction

      // Bjorklund pair folding, then a right rotation modulo the step count.
      function logic [31:0] euclid_pattern(logic [5:0] hit_count, logic [5:0] step_count,
                                           logic [7:0] rotate_by);
         int unsigned hits, steps, rot, left, right, pairs, extra, src, dst, pos;
         logic [63:0] grp [64];
         int unsigned glen [64];
         logic [63:0] pat, mask;
         hits = 32'(hit_count);
         steps = 32'(step_count);
         rot = 32'(rotate_by);
         pat = '0;
         if (steps > MAX_STEPS) steps = MAX_STEPS;
         if (steps > 64) steps = 64;
         if (steps == 0) return '0;
         if (hits > steps) hits = steps;
         mask = (steps >= 64) ? '1 : ((64'd1 << steps) - 64'd1);
         if (hits == steps) begin
            pat = mask;
         end else if (hits != 0) begin
            for (int i = 0; i < steps; i++) begin
               grp[i] = (i < hits) ? 64'd1 : 64'd0;
               glen[i] = 1;
            end
            left = hits;
            right = steps - hits;
            while (right > 1) begin
               pairs = (left < right) ? left : right;
               for (int i = 0; i < pairs; i++) begin
                  src = (left + i) & 63;
                  if (glen[i] < 64) grp[i] = grp[i] | (grp[src] << glen[i]);
                  glen[i] = glen[i] + glen[src];
               end
               if (left > right) begin
                  right = left - pairs;
                  left = pairs;
               end else begin
                  // Unpaired remainder groups slide down behind the merged ones.
                  extra = right - pairs;
                  for (int i = 0; i < extra; i++) begin
                     src = (left + pairs + i) & 63;
                     dst = (pairs + i) & 63;
                     grp[dst] = grp[src];
                     glen[dst] = glen[src];
                  end
                  right = right - pairs;
                  left = pairs;
               end
            end
            pos = 0;
            for (int i = 0; i < left + right && i < 64 && pos < 64; i++) begin
               pat = pat | (grp[i] << pos);
               pos = pos + glen[i];
            end
            pat = pat & mask;
         end
         rot = rot % steps;
         if (rot != 0) pat = ((pat >> rot) | (pat << (steps - rot))) & mask;
         return pat[31:0];
      endfunction

      function void note_request(logic [5:0] hit_count, logic [5:0] step_count,
                                 logic [7:0] rotate_by);
         expected_patterns.push_back(euclid_pattern(hit_count, step_count, rotate_by));
      endfunction

      function void check_pattern(logic [31:0] actual);
         logic [31:0] wanted;
         if (expected_patterns.size() == 0) begin
            $error("pattern_bits: no result expected, actual 0x%08h", actual);
            mismatches++;
            return;
         end
         wanted = expected_patterns.pop_front();
         checked++;
         if (actual !== wanted) begin
            $error("pattern_bits: expected 0x%08h, actual 0x%08h", wanted, actual);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_patterns.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [5:0]  req_hit_count = '0;
   logic [5:0]  req_step_count = '0;
   logic [7:0]  req_rotate_by = '0;
   logic        rsp_valid;
   logic [31:0] rsp_pattern_bits;

   rhythm_scoreboard scoreboard = new();
   bit          sender_gaps = 1'b1;
   int unsigned requests_sent = 0;
   int unsigned quiet_cycles = 0;

   euclidean_rhythm_generator #(
      .MAX_STEPS(MAX_STEPS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_hit_count   (req_hit_count),
      .req_step_count  (req_step_count),
      .req_rotate_by   (req_rotate_by),
      .rsp_valid       (rsp_valid),
      .rsp_pattern_bits(rsp_pattern_bits)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Both transactions are sampled with the values that stood before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) scoreboard.check_pattern(rsp_pattern_bits);
         if (start && !busy) scoreboard.note_request(req_hit_count, req_step_count,
                                                     req_rotate_by);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("timeout: %0d cycles without a transaction", STALL_LIMIT);
         $display("tb_euclidean_rhythm_generator: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one request, holds it until accepted, then sometimes drops start for a while.
   task automatic issue(input logic [5:0] hit_count, input logic [5:0] step_count,
                        input logic [7:0] rotate_by);
      req_hit_count <= hit_count;
      req_step_count <= step_count;
      req_rotate_by <= rotate_by;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
      if (sender_gaps && $urandom_range(99) < 19) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
   endtask

   initial begin
      logic [5:0] hits, steps;
      logic [7:0] rot;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Corner cases: empty patterns, clamped and full hit counts, saturated step counts,
      // rotations that are whole multiples of the length, and the widest masks.
      issue(6'd0, 6'd0, 8'd0);
      issue(6'd5, 6'd0, 8'd200);
      issue(6'd0, 6'd16, 8'd3);
      issue(6'd16, 6'd16, 8'd0);
      issue(6'd63, 6'd20, 8'd5);
      issue(6'd3, 6'd8, 8'd0);
      issue(6'd5, 6'd8, 8'd0);
      issue(6'd5, 6'd13, 8'd0);
      issue(6'd7, 6'd16, 8'd0);
      issue(6'd5, 6'd63, 8'd7);
      issue(6'd31, 6'd33, 8'd0);
      issue(6'd20, 6'd40, 8'd255);
      issue(6'd3, 6'd8, 8'd8);
      issue(6'd3, 6'd8, 8'd16);
      issue(6'd4, 6'd15, 8'd255);
      issue(6'd1, 6'd32, 8'd31);
      issue(6'd31, 6'd32, 8'd1);
      issue(6'd1, 6'd2, 8'd1);
      issue(6'd1, 6'd1, 8'd0);
      issue(6'd0, 6'd1, 8'd0);
      issue(6'd32, 6'd32, 8'd0);
      issue(6'd62, 6'd63, 8'd254);
      issue(6'd17, 6'd63, 8'd128);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_gaps = !(n >= QUIET_FIRST && n < QUIET_LAST);
         // Most requests fold a real rhythm; the rest span the whole field ranges.
         if ($urandom_range(9) < 6) begin
            steps = 6'($urandom_range(2, MAX_STEPS));
            hits = 6'($urandom_range(1, steps - 1));
         end else begin
            steps = 6'($urandom_range(63));
            hits = 6'($urandom_range(63));
         end
         rot = 8'($urandom_range(255));
         issue(hits, steps, rot);
      end
      start <= 1'b0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);

      $display("covered %0d requests (directed corners plus random lengths, hits, rotations)",
               requests_sent);
      $display("checked %0d patterns, %0d mismatches", scoreboard.checked,
               scoreboard.mismatches);
      if (scoreboard.mismatches == 0) begin
         $display("tb_euclidean_rhythm_generator: done, clean");
      end else begin
         $display("tb_euclidean_rhythm_generator: done, errors");
      end
      $finish;
   end

endmodule

@@ euclidean_rhythm_generator.f @@
+incdir+rtl
rtl/erg_pkg.sv
rtl/erg_shifter.sv
rtl/erg_modulo.sv
rtl/euclidean_rhythm_generator.sv
tb/sv/tb_euclidean_rhythm_generator.sv
